@@ src/srts_pkg.sv @@
// Shared types, widths and constants for the step-rate timer setting block.
// No dependencies; imported by every module of the block.
`default_nettype none

package srts_pkg;

  localparam int RATE_W  = 9;
  localparam int STEPS_W = 16;
  localparam int LEAD_W  = 8;
  localparam int CLK_W   = 26;
  localparam int LEAD6_W = LEAD_W + 3;
  localparam int NUM_W   = CLK_W + LEAD6_W;
  localparam int DEN_W   = RATE_W + STEPS_W + 1;
  localparam int SEL_W   = 3;
  localparam int CMP_W   = 8;
  localparam int ST_W    = 2;
  localparam int IDX_W   = 2;
  localparam int CFG_W   = CLK_W;
  localparam int PIDX_W  = 3;
  localparam int SHIFT_W = 4;
  localparam int DIV_CNT_W = $clog2(NUM_W);

  localparam int COMPARE_MAX    = 255;
  localparam int NUM_PRESCALERS = 7;
  localparam int RATE_LIMIT     = 500;

  localparam logic [STEPS_W-1:0] STEPS_RESET = STEPS_W'(6400);
  localparam logic [LEAD_W-1:0]  LEAD_RESET  = LEAD_W'(20);
  localparam logic [CLK_W-1:0]   CLK_RESET   = CLK_W'(16000000);

  // register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_STEPS_PER_REV = 2'd0;
  localparam logic [IDX_W-1:0] REG_LEAD_TENTHS   = 2'd1;
  localparam logic [IDX_W-1:0] REG_CLOCK_HZ      = 2'd2;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_TOO_SLOW = 2'd1;
  localparam logic [ST_W-1:0] ST_TOO_FAST = 2'd2;
  localparam logic [ST_W-1:0] ST_STOPPED  = 2'd3;

  localparam logic [SEL_W-1:0] CS_STOPPED = 3'd0;

  // log2 of prescalers 1, 8, 32, 64, 128, 256, 1024
  function automatic logic [SHIFT_W-1:0] presc_shift(input logic [PIDX_W-1:0] idx);
    logic [SHIFT_W-1:0] s;
    unique case (idx)
      3'd0:    s = 4'd0;
      3'd1:    s = 4'd3;
      3'd2:    s = 4'd5;
      3'd3:    s = 4'd6;
      3'd4:    s = 4'd7;
      3'd5:    s = 4'd8;
      default: s = 4'd10;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ src/step_rate_timer_setting.sv @@
// A stopped or zero-step setting goes from accept straight to the output load; any other setting
// passes through the multiply states S_NUM and S_DEN, a divider start state, a bit-serial divide,
// a capture of the quotient, a scan of one prescaler per cycle, then the output load.
// One transaction at a time: the next is accepted the cycle after the result loads, and a
// loaded result waits meanwhile.
// Synchronous reset restores the default setting registers and empties the block.
`default_nettype none

module step_rate_timer_setting
  import srts_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [RATE_W-1:0]  axis_rate,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [SEL_W-1:0]        clock_select,
  output logic [CMP_W-1:0]        compare_value,
  output logic [ST_W-1:0]         rate_status,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_NUM, S_DEN, S_GO, S_WAIT, S_SCAN, S_DONE
  } state_t;

  state_t state;

  logic [STEPS_W-1:0] steps_per_rev;
  logic [LEAD_W-1:0]  lead_tenths;
  logic [CLK_W-1:0]   clock_hz;

  logic [RATE_W-1:0]  rate;
  logic [NUM_W-1:0]   num;
  logic [DEN_W-1:0]   den;
  logic [NUM_W-1:0]   q;
  logic [PIDX_W-1:0]  pidx;
  logic [SEL_W-1:0]   res_sel;
  logic [CMP_W-1:0]   res_cmp;
  logic [ST_W-1:0]    res_st;

  logic [RATE_W-1:0]  rate_clamped;
  logic [LEAD6_W-1:0] lead6;
  logic [NUM_W-1:0]   v;
  logic               div_done;
  logic [NUM_W-1:0]   div_q;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign rate_clamped = (axis_rate > RATE_W'(RATE_LIMIT)) ? RATE_W'(RATE_LIMIT) : axis_rate;
  assign lead6 = (LEAD6_W'(lead_tenths) << 2) + (LEAD6_W'(lead_tenths) << 1);
  assign v = q >> presc_shift(pidx);

  srts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_GO),
    .dividend (num),
    .divisor  (den),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_rev <= STEPS_RESET;
      lead_tenths   <= LEAD_RESET;
      clock_hz      <= CLK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STEPS_PER_REV: steps_per_rev <= cfg_data[STEPS_W-1:0];
        REG_LEAD_TENTHS:   lead_tenths   <= cfg_data[LEAD_W-1:0];
        REG_CLOCK_HZ:      clock_hz      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // S_DONE loads the output register itself
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            rate <= rate_clamped;
            pidx <= '0;
            if (rate_clamped == '0) begin
              res_sel <= CS_STOPPED;
              res_cmp <= '0;
              res_st  <= ST_STOPPED;
              state   <= S_DONE;
            end else if (steps_per_rev == '0) begin
              res_sel <= SEL_W'(NUM_PRESCALERS);
              res_cmp <= CMP_W'(COMPARE_MAX);
              res_st  <= ST_TOO_SLOW;
              state   <= S_DONE;
            end else begin
              state <= S_NUM;
            end
          end
        end
        S_NUM: begin
          num   <= NUM_W'(clock_hz) * NUM_W'(lead6);
          state <= S_DEN;
        end
        S_DEN: begin
          den   <= DEN_W'(rate * steps_per_rev) << 1;
          state <= S_GO;
        end
        S_GO: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            q     <= div_q;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // try one prescaler per cycle, smallest first
          if (v == '0) begin
            res_sel <= SEL_W'(pidx) + 1'b1;
            res_cmp <= '0;
            res_st  <= ST_TOO_FAST;
            state   <= S_DONE;
          end else if (v <= NUM_W'(COMPARE_MAX + 1)) begin
            res_sel <= SEL_W'(pidx) + 1'b1;
            res_cmp <= CMP_W'(v - 1'b1);
            res_st  <= ST_OK;
            state   <= S_DONE;
          end else if (pidx == PIDX_W'(NUM_PRESCALERS - 1)) begin
            res_sel <= SEL_W'(NUM_PRESCALERS);
            res_cmp <= CMP_W'(COMPARE_MAX);
            res_st  <= ST_TOO_SLOW;
            state   <= S_DONE;
          end else begin
            pidx <= pidx + 1'b1;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            clock_select  <= res_sel;
            compare_value <= res_cmp;
            rate_status   <= res_st;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/srts_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on srts_pkg for operand widths.
`default_nettype none

module srts_div
  import srts_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  done,
  output logic [NUM_W-1:0]      quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] count;
  logic [DEN_W-1:0]     rem;
  logic [DEN_W-1:0]     den;
  logic [DEN_W:0]       trial;
  logic                 fits;

  assign trial = {rem, quotient[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        count    <= DIV_CNT_W'(NUM_W - 1);
        rem      <= '0;
        den      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        // shift in next dividend bit, subtract when the divisor fits
        if (fits) begin
          rem <= DEN_W'(trial - {1'b0, den});
        end else begin
          rem <= trial[DEN_W-1:0];
        end
        quotient <= {quotient[NUM_W-2:0], fits};
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          count <= count - 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ src/srts_checker.sv @@
// Port-level checks for step_rate_timer_setting, attached by bind.
// Depends on srts_pkg for codes and limits.
`default_nettype none

module srts_checker
  import srts_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [SEL_W-1:0]  clock_select,
  input wire logic [CMP_W-1:0]  compare_value,
  input wire logic [ST_W-1:0]   rate_status
);

  a_stopped: assert property (@(posedge clk) disable iff (rst)
    out_valid && rate_status == ST_STOPPED |-> clock_select == CS_STOPPED &&
      compare_value == '0)
    else $error("stopped result with nonzero timer setting");

  a_running_sel: assert property (@(posedge clk) disable iff (rst)
    out_valid && rate_status != ST_STOPPED |-> clock_select != CS_STOPPED)
    else $error("running result with stopped clock select");

  a_too_slow: assert property (@(posedge clk) disable iff (rst)
    out_valid && rate_status == ST_TOO_SLOW |->
      clock_select == SEL_W'(NUM_PRESCALERS) && compare_value == CMP_W'(COMPARE_MAX))
    else $error("too-slow result not clamped at last prescaler");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again while a transaction is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(clock_select) &&
      $stable(compare_value) && $stable(rate_status))
    else $error("stalled result changed");

endmodule

bind step_rate_timer_setting srts_checker u_srts_checker (.*);

`default_nettype wire
